/* rtl/sra_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the slot region allocator.
// No dependencies; imported by sra_region_unit, slot_region_allocator and the testbench.
package sra_pkg;

    localparam int SLOTS_PER_BUFFER = 512;
    localparam int MAX_BUFFERS      = 16;
    localparam int MAX_REGIONS      = 64;

    // Port field widths are fixed by the interface.
    localparam int SLOT_W  = 9;
    localparam int BUF_W   = 4;

    localparam int START_W = $clog2(SLOTS_PER_BUFFER + 1);
    localparam int IDX_W   = $clog2(MAX_REGIONS);
    localparam int LIVE_W  = $clog2(MAX_REGIONS + 1);
    localparam int BUFN_W  = $clog2(MAX_BUFFERS + 1);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_BUFFER  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [START_W-1:0] length;
        logic [BUF_W-1:0]   buffer;
    } region_t;

    localparam int REGION_W = $bits(region_t);

    // flag: on acquire, region is now empty; on release, region borders the slot
    typedef struct packed {
        logic    flag;
        region_t entry;
    } region_upd_t;

endpackage

/* rtl/sra_region_ram.sv */
`timescale 1ns / 1ps
// Single-port region table memory with registered read data.
// Generic; no package dependency.
module sra_region_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/sra_region_unit.sv */
`timescale 1ns / 1ps
// Shared region update unit: border compare for release, slot take for acquire.
// Depends on sra_pkg.
module sra_region_unit
    import sra_pkg::*;
(
    input  logic              rel_mode,
    input  region_t           entry,
    input  logic [BUF_W-1:0]  buffer_number,
    input  logic [SLOT_W-1:0] slot_number,
    output region_upd_t       upd
);

    logic [START_W:0] slot_ext;
    logic [START_W:0] slot_up;
    logic [START_W:0] end_ext;
    logic             same_buf;
    logic             hit_low;
    logic             hit_high;
    logic [START_W-1:0] len_dec;

    assign slot_ext = (START_W + 1)'(slot_number);
    assign slot_up  = slot_ext + 1'b1;
    assign end_ext  = {1'b0, entry.start} + {1'b0, entry.length};
    assign same_buf = (entry.buffer == buffer_number);
    assign hit_low  = same_buf && ({1'b0, entry.start} == slot_up);
    assign hit_high = same_buf && (end_ext == slot_ext);
    assign len_dec  = (entry.length != '0) ? entry.length - 1'b1 : '0;

    always_comb
    begin
        upd.entry = entry;
        upd.flag  = 1'b0;
        if (!rel_mode)
        begin
            upd.entry.start  = entry.start + 1'b1;
            upd.entry.length = len_dec;
            upd.flag         = (len_dec == '0);
        end
        else if (hit_low)
        begin
            // grow downward: region starts just above the freed slot
            upd.entry.start  = slot_ext[START_W-1:0];
            upd.entry.length = entry.length + 1'b1;
            upd.flag         = 1'b1;
        end
        else if (hit_high)
        begin
            upd.entry.length = entry.length + 1'b1;
            upd.flag         = 1'b1;
        end
    end

endmodule

/* rtl/slot_region_allocator.sv */
`timescale 1ns / 1ps
// Slot region allocator: hands out and takes back slots in 512-slot buffers
// (up to 16 buffers), keeping free space as a table of up to 64 regions in a
// single-port memory. One item is in flight at a time; in_ready is high only
// while the sequencer is idle. From acceptance to the result beat, an acquire
// reads the top region, updates it and registers the output; a release
// searches the live regions for a border, one table entry per cycle through
// the memory port and one shared compare unit, and appends a region if none
// borders the slot. A result waiting on out_ready stalls the next item.
// Depends on sra_pkg, sra_region_ram and sra_region_unit.
module slot_region_allocator
    import sra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [BUF_W-1:0]  buffer_number,
    input  logic [SLOT_W-1:0] slot_number,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SLOT_W-1:0] given_slot,
    output logic [BUF_W-1:0]  given_buffer,
    output logic              opened_buffer,
    output logic [1:0]        status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACQ,
        S_OPEN,
        S_SCAN,
        S_APPEND,
        S_OUT
    } state_t;

    state_t             state_reg;
    logic               op_reg;
    logic [BUF_W-1:0]   buf_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LIVE_W-1:0]  idx_reg;
    logic [LIVE_W-1:0]  live_reg;
    logic [BUFN_W-1:0]  bo_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [BUF_W-1:0]   res_buf_reg;
    logic               res_open_reg;
    status_t            res_status_reg;
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [BUF_W-1:0]   out_buf_reg;
    logic               out_open_reg;
    status_t            out_status_reg;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    region_t            mem_wdata;
    logic [REGION_W-1:0] mem_rdata;
    region_t            rd_entry;
    region_upd_t        upd;

    logic [LIVE_W-1:0]  live_m1;
    logic [LIVE_W-1:0]  idx_inc;
    logic               buf_left;
    logic               table_room;
    logic               rel_bad;
    region_t            open_entry;
    region_t            new_entry;

    assign rd_entry   = region_t'(mem_rdata);
    assign live_m1    = live_reg - 1'b1;
    assign idx_inc    = idx_reg + 1'b1;
    assign buf_left   = (bo_reg < BUFN_W'(MAX_BUFFERS));
    assign table_room = (live_reg < LIVE_W'(MAX_REGIONS));
    assign rel_bad    = ((BUFN_W + BUF_W)'(buffer_number) >= (BUFN_W + BUF_W)'(bo_reg))
                     || ((START_W + 1)'(slot_number) >= (START_W + 1)'(SLOTS_PER_BUFFER));

    // fresh buffer with slot 0 already taken
    assign open_entry.start  = START_W'(1);
    assign open_entry.length = START_W'(SLOTS_PER_BUFFER - 1);
    assign open_entry.buffer = BUF_W'(bo_reg);

    assign new_entry.start  = START_W'(slot_reg);
    assign new_entry.length = START_W'(1);
    assign new_entry.buffer = buf_reg;

    sra_region_ram #(
        .WIDTH (REGION_W),
        .DEPTH (MAX_REGIONS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sra_region_unit u_unit (
        .rel_mode      (op_reg),
        .entry         (rd_entry),
        .buffer_number (buf_reg),
        .slot_number   (slot_reg),
        .upd           (upd)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = live_m1[IDX_W-1:0];
        mem_wdata = upd.entry;
        unique case (state_reg)
            S_IDLE:
            begin
                // prefetch: top region for acquire, entry 0 for release
                mem_addr = op ? '0 : live_m1[IDX_W-1:0];
            end
            S_ACQ:
            begin
                mem_we = 1'b1;
            end
            S_OPEN:
            begin
                mem_addr  = '0;
                mem_we    = buf_left;
                mem_wdata = open_entry;
            end
            S_SCAN:
            begin
                if (upd.flag)
                begin
                    mem_we   = 1'b1;
                    mem_addr = idx_reg[IDX_W-1:0];
                end
                else
                begin
                    mem_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_APPEND:
            begin
                mem_addr  = live_reg[IDX_W-1:0];
                mem_we    = table_room;
                mem_wdata = new_entry;
            end
            S_OUT:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_reg       <= '0;
            bo_reg         <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= 1'b0;
            buf_reg        <= '0;
            slot_reg       <= '0;
            res_slot_reg   <= '0;
            res_buf_reg    <= '0;
            res_open_reg   <= 1'b0;
            res_status_reg <= ST_OK;
            out_slot_reg   <= '0;
            out_buf_reg    <= '0;
            out_open_reg   <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // in S_OUT the output register is reloaded below instead
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= op;
                        buf_reg        <= buffer_number;
                        slot_reg       <= slot_number;
                        idx_reg        <= '0;
                        res_slot_reg   <= '0;
                        res_buf_reg    <= '0;
                        res_open_reg   <= 1'b0;
                        res_status_reg <= ST_OK;
                        if (!op)
                        begin
                            state_reg <= (live_reg == '0) ? S_OPEN : S_ACQ;
                        end
                        else if (rel_bad)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= (live_reg == '0) ? S_APPEND : S_SCAN;
                        end
                    end
                end
                S_ACQ:
                begin
                    res_slot_reg <= rd_entry.start[SLOT_W-1:0];
                    res_buf_reg  <= rd_entry.buffer;
                    if (upd.flag)
                    begin
                        live_reg <= live_m1;
                    end
                    state_reg <= S_OUT;
                end
                S_OPEN:
                begin
                    if (buf_left)
                    begin
                        live_reg     <= LIVE_W'(1);
                        bo_reg       <= bo_reg + 1'b1;
                        res_buf_reg  <= BUF_W'(bo_reg);
                        res_open_reg <= 1'b1;
                    end
                    else
                    begin
                        res_status_reg <= ST_NO_BUFFER;
                    end
                    state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    if (upd.flag)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (idx_inc < live_reg)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        state_reg <= S_APPEND;
                    end
                end
                S_APPEND:
                begin
                    if (table_room)
                    begin
                        live_reg <= live_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_reg <= ST_TABLE_FULL;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_slot_reg   <= res_slot_reg;
                        out_buf_reg    <= res_buf_reg;
                        out_open_reg   <= res_open_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign given_slot    = out_slot_reg;
    assign given_buffer  = out_buf_reg;
    assign opened_buffer = out_open_reg;
    assign status        = out_status_reg;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for slot_region_allocator: a directed table, then random acquire/release traffic.
// Every result beat is checked against a typed-in expectation or a local model of the free-region table.
// Depends on sra_pkg and the RTL in rtl/.
module testbench
    import sra_pkg::*;
();

    localparam logic OP_ACQUIRE    = 1'b0;
    localparam logic OP_RELEASE    = 1'b1;
    localparam int   CYCLE_LIMIT   = 4_000_000;
    localparam int   SETTLE_CYCLES = MAX_REGIONS + 16;
    localparam int   LONG_HOLD     = 400;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [BUF_W-1:0]  bufn;
        logic              opened;
        status_t           status;
    } grant_t;

    typedef struct packed {
        logic [BUF_W-1:0]  bufn;
        logic [SLOT_W-1:0] slot;
    } slot_ref_t;

    typedef struct packed {
        logic              op;
        logic [BUF_W-1:0]  bufn;
        logic [SLOT_W-1:0] slot;
        logic              typed;
        grant_t            want;
    } stim_row_t;

    localparam grant_t NO_GRANT = '{9'd0, 4'd0, 1'b0, ST_OK};

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              op;
    logic [BUF_W-1:0]  buffer_number;
    logic [SLOT_W-1:0] slot_number;
    logic              out_valid;
    logic              out_ready;
    logic [SLOT_W-1:0] given_slot;
    logic [BUF_W-1:0]  given_buffer;
    logic              opened_buffer;
    logic [1:0]        status;

    // free-region table as the allocator should hold it
    int free_start [MAX_REGIONS];
    int free_len   [MAX_REGIONS];
    int free_bufn  [MAX_REGIONS];
    int free_count   = 0;
    int opened_count = 0;

    grant_t    pending_grants[$];
    slot_ref_t handed_out[$];
    int        errors          = 0;
    int        grants_seen     = 0;
    int        no_buffer_hits  = 0;
    int        table_full_hits = 0;
    int        burst_left      = 0;
    int        cycles          = 0;

    // Typed-in expectations only where obvious; other rows go through predict_grant.
    stim_row_t directed_rows [22] = '{
        '{OP_RELEASE, 4'd0,  9'd0,   1'b1, NO_GRANT},             // nothing open yet
        '{OP_RELEASE, 4'd15, 9'd511, 1'b1, NO_GRANT},
        '{OP_ACQUIRE, 4'd15, 9'd511, 1'b1, '{9'd0, 4'd0, 1'b1, ST_OK}},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b1, '{9'd1, 4'd0, 1'b0, ST_OK}},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b1, '{9'd2, 4'd0, 1'b0, ST_OK}},
        '{OP_RELEASE, 4'd1,  9'd0,   1'b1, NO_GRANT},             // buffer 1 not open
        '{OP_RELEASE, 4'd0,  9'd2,   1'b0, NO_GRANT},             // grows region down
        '{OP_RELEASE, 4'd0,  9'd0,   1'b0, NO_GRANT},             // no border: append
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},             // empties last region
        '{OP_RELEASE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_RELEASE, 4'd0,  9'd0,   1'b0, NO_GRANT},             // same slot twice
        '{OP_RELEASE, 4'd0,  9'd100, 1'b0, NO_GRANT},             // slot that is still free
        '{OP_RELEASE, 4'd0,  9'd101, 1'b0, NO_GRANT},             // grows region up
        '{OP_RELEASE, 4'd0,  9'd1,   1'b0, NO_GRANT},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_RELEASE, 4'd0,  9'd511, 1'b0, NO_GRANT},
        '{OP_RELEASE, 4'd0,  9'd510, 1'b0, NO_GRANT},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_ACQUIRE, 4'd0,  9'd0,   1'b0, NO_GRANT},
        '{OP_RELEASE, 4'd1,  9'd511, 1'b1, NO_GRANT}
    };

    slot_region_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .buffer_number (buffer_number),
        .slot_number   (slot_number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .given_slot    (given_slot),
        .given_buffer  (given_buffer),
        .opened_buffer (opened_buffer),
        .status        (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic grant_t predict_grant(input logic op_i, input logic [BUF_W-1:0] bufn_i,
                                             input logic [SLOT_W-1:0] slot_i);
        grant_t g;
        int     top;
        int     idx;
        int     s;
        g.slot   = '0;
        g.bufn   = '0;
        g.opened = 1'b0;
        g.status = ST_OK;
        s        = slot_i;
        if (op_i == OP_ACQUIRE)
        begin
            if (free_count == 0)
            begin
                if (opened_count >= MAX_BUFFERS)
                begin
                    g.status = ST_NO_BUFFER;
                    return g;
                end
                free_start[0] = 0;
                free_len[0]   = SLOTS_PER_BUFFER;
                free_bufn[0]  = opened_count;
                opened_count++;
                free_count = 1;
                g.opened   = 1'b1;
            end
            top    = free_count - 1;
            g.slot = SLOT_W'(free_start[top]);
            g.bufn = BUF_W'(free_bufn[top]);
            free_start[top]++;
            if (free_len[top] > 0)
                free_len[top]--;
            if (free_len[top] == 0)
                free_count--;
            return g;
        end
        if (bufn_i >= opened_count || s >= SLOTS_PER_BUFFER)
            return g;
        // first region in the same buffer that touches the slot wins
        for (idx = 0; idx < free_count; idx++)
        begin
            if (free_bufn[idx] == bufn_i)
            begin
                if (free_start[idx] == s + 1)
                begin
                    free_start[idx] = s;
                    free_len[idx]++;
                    return g;
                end
                if (s == free_start[idx] + free_len[idx])
                begin
                    free_len[idx]++;
                    return g;
                end
            end
        end
        if (free_count >= MAX_REGIONS)
            g.status = ST_TABLE_FULL;
        else
        begin
            free_start[free_count] = s;
            free_len[free_count]   = 1;
            free_bufn[free_count]  = bufn_i;
            free_count++;
        end
        return g;
    endfunction

    task automatic send_beat(input logic op_i, input logic [BUF_W-1:0] bufn_i,
                             input logic [SLOT_W-1:0] slot_i, input logic typed_i,
                             input grant_t want_i);
        grant_t got;
        int     gap;
        in_valid      <= 1'b1;
        op            <= op_i;
        buffer_number <= bufn_i;
        slot_number   <= slot_i;
        do
            @(posedge clk);
        while (!in_ready);
        got = predict_grant(op_i, bufn_i, slot_i);
        if (op_i == OP_ACQUIRE && got.status == ST_OK)
            handed_out.insert(handed_out.size(), '{got.bufn, got.slot});
        if (got.status == ST_NO_BUFFER)
            no_buffer_hits++;
        if (got.status == ST_TABLE_FULL)
            table_full_hits++;
        pending_grants.insert(pending_grants.size(), typed_i ? want_i : got);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(8, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(120, 40) : $urandom_range(20);
        end
    endtask

    // Mostly gives back slots that were handed out; the rest are neighbors of those
    // (often double releases) and fully random buffer/slot pairs.
    task automatic random_beat(input int acquire_pct);
        slot_ref_t         pick;
        int                idx;
        int                kind;
        logic [BUF_W-1:0]  nb;
        logic [SLOT_W-1:0] ns;
        nb   = BUF_W'($urandom);
        ns   = SLOT_W'($urandom);
        kind = $urandom_range(99);
        if (kind < acquire_pct)
            send_beat(OP_ACQUIRE, nb, ns, 1'b0, NO_GRANT);
        else
        begin
            kind = $urandom_range(9);
            if (kind < 8 && handed_out.size() != 0)
            begin
                idx  = $urandom_range(handed_out.size() - 1);
                pick = handed_out[idx];
                nb   = pick.bufn;
                if (kind == 7)
                    ns = ($urandom_range(1) == 1) ? pick.slot + 1'b1 : pick.slot - 1'b1;
                else
                begin
                    ns              = pick.slot;
                    handed_out[idx] = handed_out[handed_out.size() - 1];
                    handed_out.delete(handed_out.size() - 1);
                end
            end
            send_beat(OP_RELEASE, nb, ns, 1'b0, NO_GRANT);
        end
    endtask

    initial
    begin
        int n;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        op            <= OP_ACQUIRE;
        buffer_number <= '0;
        slot_number   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].bufn, directed_rows[i].slot,
                      directed_rows[i].typed, directed_rows[i].want);
        repeat (600) random_beat(55);
        // release-heavy: push the region table toward its limit
        n = 0;
        while (table_full_hits < 6 && n < 300)
        begin
            random_beat(15);
            n++;
        end
        // acquire-heavy
        n = 0;
        while (no_buffer_hits < 10 && n < 300)
        begin
            random_beat(95);
            n++;
        end
        repeat (150) random_beat(50);
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: stall modes change at random, plus one long hold
    initial
    begin
        int   mode;
        int   mode_left;
        bit   long_hold_done;
        logic nxt;
        mode           = 0;
        mode_left      = 0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && grants_seen >= 150)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(96, 16);
            end
            mode_left--;
            case (mode)
                0:       nxt = 1'b1;
                1:       nxt = ($urandom_range(1) == 1);
                default: nxt = ($urandom_range(3) == 0);
            endcase
            out_ready <= nxt;
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            grants_seen++;
            if (pending_grants.size() == 0)
            begin
                $error("result beat with no expectation pending");
                errors++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (given_slot !== want.slot)
                begin
                    $error("given_slot: expected %0d, got %0d", want.slot, given_slot);
                    errors++;
                end
                if (given_buffer !== want.bufn)
                begin
                    $error("given_buffer: expected %0d, got %0d", want.bufn, given_buffer);
                    errors++;
                end
                if (opened_buffer !== want.opened)
                begin
                    $error("opened_buffer: expected %0d, got %0d", want.opened, opened_buffer);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

/* files.f */
rtl/sra_pkg.sv
rtl/sra_region_ram.sv
rtl/sra_region_unit.sv
rtl/slot_region_allocator.sv
dv/testbench.sv
